// ----- sv/rss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rss_pkg;
  localparam int MUL_W   = 64;
  localparam int DIG_W   = 16;
  localparam int MUL_ND  = MUL_W / DIG_W;
  localparam int MCNT_W  = $clog2(MUL_ND + 1);
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DIV_W   = 128;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int TOTAL_W = 64;
  localparam int SPREAD_W = 63;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [SPREAD_W-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_res_t;
endpackage
`default_nettype wire

// ----- sv/running_sample_statistics.sv -----
// The back end takes one beat at a time: the bit-serial divider runs SAMPLE_WIDTH+1 steps for
//   the mean and 128 steps for the variance, with two 4-step multiplies and the sequencer's
//   hand-offs between them, and a result shown by empty falling waits until it is popped.
// A 2-deep input queue takes beats while the back end works or a result waits.
// Reset (rst_n low, synchronous) empties the input queue, drops any waiting result and zeroes
//   all statistics.
`timescale 1ns / 1ps
`default_nettype none
module running_sample_statistics #(
  parameter int SAMPLE_WIDTH  = 48,
  parameter int FRACTION_BITS = 16,
  parameter int COUNT_WIDTH   = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_sample_value,
  input  wire logic                              in_clear_first,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [SAMPLE_WIDTH-1:0]         out_minimum,
  output logic signed [SAMPLE_WIDTH-1:0]         out_maximum,
  output logic signed [rss_pkg::TOTAL_W-1:0]     out_total,
  output logic [COUNT_WIDTH-1:0]                 out_sample_count,
  output logic signed [SAMPLE_WIDTH-1:0]         out_average,
  output logic [rss_pkg::SPREAD_W-1:0]           out_spread
);
  import rss_pkg::*;

  localparam int ITEM_W = SAMPLE_WIDTH + 1;

  logic [ITEM_W-1:0] head;
  logic              head_avail, head_take, res_valid;

  // front: input queue, clear flag rides in the top bit
  rss_fifo #(.WIDTH(ITEM_W)) u_front (
    .clk, .rst_n,
    .wr_en(push), .wr_data({in_clear_first, in_sample_value}), .full_o(full),
    .rd_en(head_take), .rd_data(head), .avail_o(head_avail)
  );

  // back: update sequencer with shared divider and multiplier
  rss_back #(.SW(SAMPLE_WIDTH), .FB(FRACTION_BITS), .CW(COUNT_WIDTH)) u_back (
    .clk, .rst_n,
    .item_avail(head_avail),
    .item_value($signed(head[SAMPLE_WIDTH-1:0])),
    .item_clear(head[ITEM_W-1]),
    .item_take(head_take),
    .min_o(out_minimum), .max_o(out_maximum), .sum_o(out_total),
    .count_o(out_sample_count), .mean_o(out_average), .var_o(out_spread),
    .valid_o(res_valid), .pop
  );

  assign empty = !res_valid;
endmodule
`default_nettype wire

// ----- sv/rss_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rss_fifo #(
  parameter int WIDTH = 49
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full_o,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  avail_o
);
  logic [WIDTH-1:0] mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign full_o  = (cnt_r == 2'd2);
  assign avail_o = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr_en && !full_o;
  assign do_rd   = rd_en && avail_o;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule
`default_nettype wire

// ----- sv/rss_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rss_div #(
  parameter int CW = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rss_pkg::DIV_W-1:0] dividend,
  input  wire logic [rss_pkg::DCNT_W-1:0] iters,
  input  wire logic [CW-1:0]             divisor,
  output rss_pkg::div_res_t              res
);
  import rss_pkg::*;

  logic              busy_r, done_r, ovf_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [CW-1:0]     rem_r;
  logic [SPREAD_W-1:0] quo_r;
  logic [CW:0]       trial;
  logic              qbit;

  // restoring step, one quotient bit per cycle
  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r <= qbit ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
      quo_r <= {quo_r[SPREAD_W-2:0], qbit};
      ovf_r <= ovf_r | quo_r[SPREAD_W-1];
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/rss_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rss_mul (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rss_pkg::MUL_W-1:0] op_a,
  input  wire logic [rss_pkg::MUL_W-1:0] op_b,
  output rss_pkg::mul_res_t              res
);
  import rss_pkg::*;

  logic              busy_r, done_r;
  logic [MCNT_W-1:0] cnt_r;
  logic [MUL_W-1:0]  a_r, b_r;
  logic [PROD_W-1:0] acc_r;
  logic [MUL_W+DIG_W-1:0] part;

  // one 16-bit digit of b per cycle, most significant first
  assign part = a_r * b_r[MUL_W-1 -: DIG_W];

  assign res.done = done_r;
  assign res.prod = acc_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      b_r   <= b_r << DIG_W;
      acc_r <= (acc_r << DIG_W) + PROD_W'(part);
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MCNT_W'(MUL_ND);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == MCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/rss_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rss_back #(
  parameter int SW = 48,
  parameter int FB = 16,
  parameter int CW = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          item_avail,
  input  wire logic signed [SW-1:0]          item_value,
  input  wire logic                          item_clear,
  output logic                               item_take,
  output logic signed [SW-1:0]               min_o,
  output logic signed [SW-1:0]               max_o,
  output logic signed [rss_pkg::TOTAL_W-1:0] sum_o,
  output logic [CW-1:0]                      count_o,
  output logic signed [SW-1:0]               mean_o,
  output logic [rss_pkg::SPREAD_W-1:0]       var_o,
  output logic                               valid_o,
  input  wire logic                          pop
);
  import rss_pkg::*;

  localparam int DW = SW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MDIV, S_MWAIT, S_MEAN, S_MUL1, S_M1WAIT,
    S_MUL2, S_M2WAIT, S_VDIV, S_VWAIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // committed statistics, shown on the result ports
  logic signed [SW-1:0]      min_r, max_r, mean_r;
  logic signed [TOTAL_W-1:0] sum_r;
  logic [CW-1:0]             count_r;
  logic [SPREAD_W-1:0]       var_r;
  logic                      valid_r;

  // per-item working set
  logic signed [SW-1:0]      v_r, mean_old_r, min_n_r, max_n_r, mean_n_r;
  logic signed [TOTAL_W-1:0] sum_n_r;
  logic [CW-1:0]             n_r;
  logic [SPREAD_W-1:0]       var_old_r, var_n_r;
  logic                      neg_r;
  logic [DW-1:0]             mag_old_r, mag_new_r;
  logic [PROD_W-1:0]         p1_r;

  // front-end classification of the head item
  logic signed [SW-1:0]      b_min, b_max, b_mean;
  logic signed [TOTAL_W-1:0] b_sum;
  logic [CW-1:0]             b_cnt;
  logic [SPREAD_W-1:0]       b_var;
  logic signed [TOTAL_W:0]   s_wide;
  logic signed [TOTAL_W-1:0] s_sat;
  logic signed [DW-1:0]      d_old;
  logic signed [DW-1:0]      q_s, mean_w, d_new;
  logic signed [SW-1:0]      mean_new;

  logic                  div_start, mul_start;
  logic [DIV_W-1:0]      div_dvd;
  logic [DCNT_W-1:0]     div_iters;
  logic [MUL_W-1:0]      mul_a, mul_b;
  div_res_t              dres;
  mul_res_t              mres;

  always_comb begin
    b_min  = item_clear ? '0 : min_r;
    b_max  = item_clear ? '0 : max_r;
    b_sum  = item_clear ? '0 : sum_r;
    b_cnt  = item_clear ? '0 : count_r;
    b_mean = item_clear ? '0 : mean_r;
    b_var  = item_clear ? '0 : var_r;
    s_wide = {b_sum[TOTAL_W-1], b_sum} + (TOTAL_W+1)'(item_value);
    if (s_wide[TOTAL_W] != s_wide[TOTAL_W-1])
      s_sat = s_wide[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    else
      s_sat = s_wide[TOTAL_W-1:0];
    d_old  = DW'(item_value) - DW'(b_mean);

    q_s      = neg_r ? -$signed(dres.quo[DW-1:0]) : $signed(dres.quo[DW-1:0]);
    mean_w   = DW'(mean_old_r) + q_s;
    mean_new = mean_w[SW-1:0];
    d_new    = DW'(v_r) - DW'(mean_new);
  end

  assign item_take = (state_r == S_IDLE) && item_avail;

  // shared divider: mean step first, then variance
  assign div_start = (state_r == S_MDIV) || (state_r == S_VDIV);
  assign div_dvd   = (state_r == S_MDIV) ? {mag_old_r, {(DIV_W-DW){1'b0}}}
                                         : (p1_r >> FB) + mres.prod;
  assign div_iters = (state_r == S_MDIV) ? DCNT_W'(DW) : DCNT_W'(DIV_W);

  assign mul_start = (state_r == S_MUL1) || (state_r == S_MUL2);
  assign mul_a = (state_r == S_MUL1) ? MUL_W'(mag_old_r) : MUL_W'(n_r - 1'b1);
  assign mul_b = (state_r == S_MUL1) ? MUL_W'(mag_new_r) : MUL_W'(var_old_r);

  rss_div #(.CW(CW)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dvd), .iters(div_iters),
    .divisor(n_r), .res(dres)
  );

  rss_mul u_mul (
    .clk, .rst_n, .start(mul_start), .op_a(mul_a), .op_b(mul_b), .res(mres)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (item_avail) state_nxt = S_MDIV;
      S_MDIV:   state_nxt = S_MWAIT;
      S_MWAIT:  if (dres.done) state_nxt = S_MEAN;
      S_MEAN:   state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_M1WAIT;
      S_M1WAIT: if (mres.done) state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_M2WAIT;
      S_M2WAIT: if (mres.done) state_nxt = S_VDIV;
      S_VDIV:   state_nxt = S_VWAIT;
      S_VWAIT:  if (dres.done) state_nxt = S_OUT;
      S_OUT:    if (!valid_r) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      v_r        <= item_value;
      mean_old_r <= b_mean;
      var_old_r  <= b_var;
      min_n_r    <= (b_cnt == '0 || item_value < b_min) ? item_value : b_min;
      max_n_r    <= (b_cnt == '0 || item_value > b_max) ? item_value : b_max;
      sum_n_r    <= s_sat;
      n_r        <= (b_cnt == '1) ? b_cnt : b_cnt + 1'b1;
      neg_r      <= d_old[DW-1];
      mag_old_r  <= d_old[DW-1] ? DW'(-d_old) : DW'(d_old);
    end
    if (state_r == S_MEAN) begin
      mean_n_r  <= mean_new;
      mag_new_r <= d_new[DW-1] ? DW'(-d_new) : DW'(d_new);
    end
    if (state_r == S_M1WAIT && mres.done) p1_r <= mres.prod;
    if (state_r == S_VWAIT && dres.done)
      var_n_r <= dres.ovf ? '1 : dres.quo;
    if (state_r == S_OUT && !valid_r) begin
      min_r   <= min_n_r;
      max_r   <= max_n_r;
      sum_r   <= sum_n_r;
      count_r <= n_r;
      mean_r  <= mean_n_r;
      var_r   <= var_n_r;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
      mean_r  <= '0;
      var_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && !valid_r) valid_r <= 1'b1;
      else if (pop) valid_r <= 1'b0;
    end
  end

  assign min_o   = min_r;
  assign max_o   = max_r;
  assign sum_o   = sum_r;
  assign count_o = count_r;
  assign mean_o  = mean_r;
  assign var_o   = var_r;
  assign valid_o = valid_r;

  a_rose_count : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> count_r != '0)
    else $error("result shown with zero count");
  a_min_max : assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && count_r != '0) |-> min_r <= max_r)
    else $error("minimum above maximum");
  a_div_done : assert property (@(posedge clk) disable iff (!rst_n)
    dres.done |-> (state_r == S_MWAIT || state_r == S_VWAIT))
    else $error("divider finished outside a wait state");
  a_mul_done : assert property (@(posedge clk) disable iff (!rst_n)
    mres.done |-> (state_r == S_M1WAIT || state_r == S_M2WAIT))
    else $error("multiplier finished outside a wait state");
endmodule
`default_nettype wire

// ----- tb/tb_running_sample_statistics.sv -----
`timescale 1ns / 1ps
module tb_running_sample_statistics;
  localparam int SW = 48;
  localparam int FB = 16;
  localparam int CW = 32;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [SW-1:0] minimum;
    logic signed [SW-1:0] maximum;
    logic signed [63:0]   total;
    logic [CW-1:0]        sample_count;
    logic signed [SW-1:0] average;
    logic [62:0]          spread;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [SW-1:0] in_sample_value = '0;
  logic in_clear_first = 1'b0;
  logic signed [SW-1:0] out_minimum, out_maximum, out_average;
  logic signed [63:0] out_total;
  logic [CW-1:0] out_sample_count;
  logic [62:0] out_spread;

  running_sample_statistics u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample_value(in_sample_value), .in_clear_first(in_clear_first),
    .empty(empty), .pop(pop),
    .out_minimum(out_minimum), .out_maximum(out_maximum), .out_total(out_total),
    .out_sample_count(out_sample_count), .out_average(out_average),
    .out_spread(out_spread)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted statistics state
  logic signed [SW-1:0] st_min, st_max, st_mean;
  logic signed [63:0]   st_sum;
  logic [CW-1:0]        st_count;
  logic [63:0]          st_var;

  stats_t expected_stats[$];
  int     errors = 0;
  longint cycles = 0;
  bit     idle_on = 1'b1;   // random idling enabled on both sides

  function automatic logic [63:0] mag64(logic signed [63:0] d);
    return d < 0 ? 64'(-d) : 64'(d);
  endfunction

  // Fold one sample into the predicted state, return the resulting beat.
  function automatic stats_t stats_update(logic signed [SW-1:0] v, logic clr);
    stats_t r;
    logic signed [63:0]  vv, diff_old, diff_new, old_mean, step, sum_w;
    logic [63:0]         n, q;
    logic [127:0]        prod, acc, quo;
    vv = 64'(v);
    if (clr) begin
      st_min = '0; st_max = '0; st_mean = '0; st_sum = '0; st_count = '0; st_var = '0;
    end
    if (st_count == 0) begin
      st_min = v; st_max = v;
    end else begin
      if (v < st_min) st_min = v;
      if (v > st_max) st_max = v;
    end
    // saturating sum: detect overflow by sign
    sum_w = st_sum + vv;
    if (vv > 0 && sum_w < st_sum) st_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (vv < 0 && sum_w > st_sum) st_sum = 64'sh8000_0000_0000_0000;
    else st_sum = sum_w;
    if (st_count != {CW{1'b1}}) st_count = st_count + 1'b1;
    n = 64'(st_count);
    old_mean = 64'(st_mean);
    diff_old = vv - old_mean;
    q = mag64(diff_old) / n;
    step = diff_old < 0 ? -$signed(q) : $signed(q);
    st_mean = SW'(old_mean + step);
    diff_new = vv - 64'(st_mean);
    prod = (128'(mag64(diff_old)) * 128'(mag64(diff_new))) >> FB;
    acc = 128'(n - 1) * 128'(st_var) + prod;
    quo = acc / 128'(n);
    st_var = (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : quo[63:0];
    r.minimum = st_min; r.maximum = st_max; r.total = st_sum;
    r.sample_count = st_count; r.average = st_mean; r.spread = st_var[62:0];
    return r;
  endfunction

  // Send one sample beat; prediction is done on acceptance.
  // push stays high after the beat; the next idle cycle or a drain drops it.
  task automatic send_sample(logic signed [SW-1:0] v, logic clr);
    while (idle_on && $urandom_range(99) < 28) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_sample_value <= v;
    in_clear_first <= clr;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_stats.push_back(stats_update(v, clr));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
  endtask

  // Result side: random pop, compare each accepted beat.
  always @(posedge clk) begin
    stats_t got, exp_s;
    cycles <= cycles + 1;
    if (rst_n && pop && !empty) begin
      got = '{out_minimum, out_maximum, out_total, out_sample_count, out_average, out_spread};
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        exp_s = expected_stats.pop_front();
        if (got.minimum !== exp_s.minimum)
          $display("%0t: minimum exp %0d got %0d", $time, exp_s.minimum, got.minimum);
        if (got.maximum !== exp_s.maximum)
          $display("%0t: maximum exp %0d got %0d", $time, exp_s.maximum, got.maximum);
        if (got.total !== exp_s.total)
          $display("%0t: total exp %0d got %0d", $time, exp_s.total, got.total);
        if (got.sample_count !== exp_s.sample_count)
          $display("%0t: count exp %0d got %0d", $time, exp_s.sample_count,
                   got.sample_count);
        if (got.average !== exp_s.average)
          $display("%0t: average exp %0d got %0d", $time, exp_s.average, got.average);
        if (got.spread !== exp_s.spread)
          $display("%0t: spread exp %0d got %0d", $time, exp_s.spread, got.spread);
        if (got !== exp_s) errors++;
      end
    end
    pop <= rst_n && !(idle_on && $urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [SW-1:0] rand_sample();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return SW'(r);
      1: return SW'($signed(r[23:0]));
      2: return SW'($signed(r[39:0]));
      default: return $urandom_range(1) ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
    endcase
  endfunction

  // Extremes, clear, first sample, mean/variance growth.
  task automatic test_directed();
    logic signed [SW-1:0] smax, smin;
    smax = {1'b0, {(SW-1){1'b1}}};
    smin = {1'b1, {(SW-1){1'b0}}};
    send_sample(48'sd65536, 1'b0);
    send_sample(-48'sd65536, 1'b0);
    send_sample('0, 1'b0);
    send_sample(smax, 1'b1);
    send_sample(smin, 1'b0);
    send_sample(smax, 1'b0);
    send_sample(smin, 1'b0);
    send_sample(48'sd3, 1'b1);
    send_sample(48'sd4, 1'b0);
    send_sample(-48'sd1, 1'b0);
    send_sample(smin, 1'b1);
    send_sample(48'sd1, 1'b0);
    wait_drained();
  endtask

  // Full-scale swings of the sum; reaching the limit needs 2^16 such beats,
  // so only the approach and the swing back are run here.
  task automatic test_sum_saturation();
    logic signed [SW-1:0] smax, smin;
    smax = {1'b0, {(SW-1){1'b1}}};
    smin = {1'b1, {(SW-1){1'b0}}};
    send_sample(smax, 1'b1);
    send_sample(smax, 1'b0);
    wait_drained();
    repeat (8) send_sample(smin, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count) begin
      send_sample(rand_sample(), $urandom_range(99) < 4);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sum_saturation();
    test_random(900);
    // sender holds off until all results are back
    wait_drained();
    idle_on = 1'b0;
    test_random(300);
    idle_on = 1'b1;
    test_random(728);
    wait_drained();
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
